FILE: src/ptw_pkg.sv
package ptw_pkg;

    localparam int VA_BITS     = 38;
    localparam int XLEN        = 64;
    localparam int VPN_W       = 27;
    localparam int VPN_SLICE_W = 9;
    localparam int PPN_W       = 44;
    localparam int PADDR_W     = 56;
    localparam int PAGE_OFS_W  = 12;
    localparam int ENTRY_OFS_W = 3;
    localparam int LEVEL_W     = 2;
    localparam int STATUS_W    = 3;
    localparam int PTE_PPN_LSB = 10;
    localparam int PTE_V_BIT   = 0;
    localparam int PTE_U_BIT   = 4;

    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEVEL_W-1:0] LEVEL_ROOT = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_MID  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd0;

    localparam logic OP_START    = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_OUT_RANGE  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_MAPPED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_USER    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BUSY       = 3'd4;

    // register index is the upper byte address bit (8-byte spacing)
    localparam logic REG_ROOT_TABLE_PPN = 1'b0;

    // classified word handed from the front to the back
    typedef struct packed {
        logic                is_resp;
        logic                out_of_range;
        logic [VPN_W-1:0]    vpn;
        logic [PPN_W-1:0]    pte_ppn;
        logic                pte_v;
        logic                pte_u;
    } ptw_item_t;

    typedef struct packed {
        logic                kind;
        logic [PADDR_W-1:0]  entry_addr;
        logic [PADDR_W-1:0]  page_addr;
        logic [STATUS_W-1:0] status;
    } ptw_result_t;

    function automatic logic [VPN_SLICE_W-1:0] vpn_slice(
        input logic [VPN_W-1:0]   vpn,
        input logic [LEVEL_W-1:0] level
    );
        logic [VPN_SLICE_W-1:0] s;
        case (level)
            LEVEL_LEAF: s = vpn[VPN_SLICE_W-1:0];
            LEVEL_MID:  s = vpn[2*VPN_SLICE_W-1:VPN_SLICE_W];
            LEVEL_ROOT: s = vpn[3*VPN_SLICE_W-1:2*VPN_SLICE_W];
            default:    s = '0;
        endcase
        return s;
    endfunction

    // table base plus index times 8; the index never carries into the ppn
    function automatic logic [PADDR_W-1:0] entry_addr_of(
        input logic [PPN_W-1:0]       ppn,
        input logic [VPN_SLICE_W-1:0] idx
    );
        return {ppn, idx, {ENTRY_OFS_W{1'b0}}};
    endfunction

endpackage

FILE: src/sv39_page_table_walker_top.sv
// Sv39 three-level page table walker, 4 KiB pages only. Push a start word
// (operation 0) with a virtual address; the walker answers with an entry read
// request (kind 0) for the root table, and each response word (operation 1)
// carrying the fetched entry yields the next request or the finished result
// (kind 1, with status and page address). Addresses at or above 2^VA_BITS and
// starts during a running walk finish at once; responses while idle are
// dropped. One word is accepted per cycle on the input side while the input
// queue is not full, and one result word can leave per cycle: a two-entry
// input queue feeds a combinational walk step that writes a two-entry result
// queue, and the step waits while that queue is full. The root table ppn
// register sits at APB address 0 and is to be written only while no walk is running.
module sv39_page_table_walker_top
    import ptw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  push,
    output logic                  full,
    input  logic                  operation,
    input  logic [XLEN-1:0]       virt_addr,
    input  logic [XLEN-1:0]       table_entry,
    output logic                  empty,
    input  logic                  pop,
    output logic                  kind,
    output logic [PADDR_W-1:0]    entry_addr,
    output logic [PADDR_W-1:0]    page_addr,
    output logic [STATUS_W-1:0]   status
);

    logic [PPN_W-1:0] root_ppn_reg;
    logic             cfg_write;
    logic             reg_sel;
    logic             item_valid;
    logic             item_take;
    ptw_item_t        item;
    ptw_result_t      result;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_ROOT_TABLE_PPN)
        begin
            prdata = APB_DATA_W'(root_ppn_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_ppn_reg <= '0;
        end
        else if (cfg_write && reg_sel == REG_ROOT_TABLE_PPN)
        begin
            root_ppn_reg <= pwdata[PPN_W-1:0];
        end
    end

    ptw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .operation   (operation),
        .virt_addr   (virt_addr),
        .table_entry (table_entry),
        .full        (full),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    ptw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .root_ppn   (root_ppn_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .empty      (empty),
        .result     (result),
        .pop        (pop)
    );

    assign kind       = result.kind;
    assign entry_addr = result.entry_addr;
    assign page_addr  = result.page_addr;
    assign status     = result.status;

endmodule

FILE: src/ptw_front.sv
module ptw_front
    import ptw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             operation,
    input  logic [XLEN-1:0]  virt_addr,
    input  logic [XLEN-1:0]  table_entry,
    output logic             full,
    output logic             item_valid,
    output ptw_item_t        item,
    input  logic             item_take
);

    ptw_item_t              entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    ptw_item_t              classified;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_comb
    begin
        classified.is_resp      = (operation == OP_RESPONSE);
        classified.out_of_range = (virt_addr[XLEN-1:VA_BITS] != '0);
        classified.vpn          = virt_addr[PAGE_OFS_W+VPN_W-1:PAGE_OFS_W];
        classified.pte_ppn      = table_entry[PTE_PPN_LSB+PPN_W-1:PTE_PPN_LSB];
        classified.pte_v        = table_entry[PTE_V_BIT];
        classified.pte_u        = table_entry[PTE_U_BIT];
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= classified;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("input queue count overflow");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> (count_reg != '0))
        else $error("accepted word missing from input queue");

endmodule

FILE: src/ptw_back.sv
module ptw_back
    import ptw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [PPN_W-1:0] root_ppn,
    input  logic             item_valid,
    input  ptw_item_t        item,
    output logic             item_take,
    output logic             empty,
    output ptw_result_t      result,
    input  logic             pop
);

    logic                   walk_active_reg, walk_active_next;
    logic [LEVEL_W-1:0]     walk_level_reg, walk_level_next;
    logic [VPN_W-1:0]       held_vpn_reg, held_vpn_next;

    ptw_result_t            entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    ptw_result_t            res;
    logic                   res_valid;
    logic                   out_full;
    logic                   do_push;
    logic                   do_pop;
    logic [LEVEL_W-1:0]     level_down;

    assign out_full   = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign item_take  = item_valid && !out_full;
    assign empty      = (count_reg == '0);
    assign result     = entries_reg[rd_ptr_reg];
    assign do_push    = item_take && res_valid;
    assign do_pop     = pop && !empty;
    assign level_down = walk_level_reg - 1'b1;

    // one walk step per word
    always_comb
    begin
        walk_active_next = walk_active_reg;
        walk_level_next  = walk_level_reg;
        held_vpn_next    = held_vpn_reg;
        res              = '0;
        res_valid        = 1'b0;
        if (item_take)
        begin
            if (!item.is_resp)
            begin
                res_valid = 1'b1;
                res.kind  = KIND_DONE;
                if (walk_active_reg)
                begin
                    res.status = STATUS_BUSY;
                end
                else if (item.out_of_range)
                begin
                    res.status = STATUS_OUT_RANGE;
                end
                else
                begin
                    held_vpn_next    = item.vpn;
                    walk_level_next  = LEVEL_ROOT;
                    walk_active_next = 1'b1;
                    res.kind         = KIND_REQUEST;
                    res.entry_addr   = entry_addr_of(root_ppn,
                                                     vpn_slice(item.vpn, LEVEL_ROOT));
                end
            end
            else if (walk_active_reg)
            begin
                // stray responses while idle fall through with no result
                res_valid = 1'b1;
                res.kind  = KIND_DONE;
                if (!item.pte_v)
                begin
                    walk_active_next = 1'b0;
                    walk_level_next  = LEVEL_LEAF;
                    res.status       = STATUS_NOT_MAPPED;
                end
                else if (walk_level_reg != LEVEL_LEAF)
                begin
                    // valid upper entry is always a pointer, no superpages
                    walk_level_next = level_down;
                    res.kind        = KIND_REQUEST;
                    res.entry_addr  = entry_addr_of(item.pte_ppn,
                                                    vpn_slice(held_vpn_reg, level_down));
                end
                else
                begin
                    walk_active_next = 1'b0;
                    if (!item.pte_u)
                    begin
                        res.status = STATUS_NO_USER;
                    end
                    else
                    begin
                        res.status    = STATUS_OK;
                        res.page_addr = {item.pte_ppn, {PAGE_OFS_W{1'b0}}};
                    end
                end
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_active_reg <= 1'b0;
            walk_level_reg  <= LEVEL_LEAF;
            held_vpn_reg    <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            walk_active_reg <= walk_active_next;
            walk_level_reg  <= walk_level_next;
            held_vpn_reg    <= held_vpn_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= res;
        end
    end

    a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
        !walk_active_reg |-> (walk_level_reg == LEVEL_LEAF))
        else $error("walk level left nonzero while idle");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        walk_active_reg |-> (walk_level_reg <= LEVEL_ROOT))
        else $error("walk level beyond root");

    a_start_request: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && !item.is_resp && !walk_active_reg && !item.out_of_range)
        |=> (walk_active_reg && walk_level_reg == LEVEL_ROOT))
        else $error("accepted start did not begin a walk");

endmodule

FILE: dv/tb_sv39_page_table_walker_top.sv
module tb_sv39_page_table_walker_top;
    import ptw_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ROOT_PPN_ADDR = {REG_ROOT_TABLE_PPN, 3'b000};
    localparam int HOLD_CYCLES = 100;

    typedef struct packed {
        logic            op;
        logic [XLEN-1:0] va;
        logic [XLEN-1:0] pte;
    } walker_word_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push = 1'b0;
    logic                  full;
    logic                  operation = OP_START;
    logic [XLEN-1:0]       virt_addr = '0;
    logic [XLEN-1:0]       table_entry = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  kind;
    logic [PADDR_W-1:0]    entry_addr;
    logic [PADDR_W-1:0]    page_addr;
    logic [STATUS_W-1:0]   status;

    // walker image kept by the testbench
    logic [PPN_W-1:0]   root_ppn = '0;
    logic               walking = 1'b0;
    logic [LEVEL_W-1:0] walk_lvl = LEVEL_LEAF;
    logic [VPN_W-1:0]   vpn_held = '0;

    walker_word_t words_to_push[$];
    ptw_result_t  walker_outputs_due[$];

    int bad_words = 0;
    int send_gap = 0;
    int take_gap = 0;
    int send_idle_pct = 0;
    int take_idle_pct = 0;
    logic want_hold = 1'b0;
    logic hold_pop = 1'b0;

    sv39_page_table_walker_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .virt_addr   (virt_addr),
        .table_entry (table_entry),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .entry_addr  (entry_addr),
        .page_addr   (page_addr),
        .status      (status)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic flag_mismatch(input string line);
        $display("%s", line);
        bad_words++;
    endtask

    // table base plus the index that the held vpn gives at the current level
    function automatic logic [PADDR_W-1:0] table_slot(input logic [PPN_W-1:0] ppn);
        logic [VPN_W-1:0] shifted;
        shifted = vpn_held >> (VPN_SLICE_W * walk_lvl);
        return (PADDR_W'(ppn) << PAGE_OFS_W)
             + (PADDR_W'(shifted[VPN_SLICE_W-1:0]) << ENTRY_OFS_W);
    endfunction

    task automatic walker_answer(input logic op, input logic [XLEN-1:0] va,
                                 input logic [XLEN-1:0] pte);
        ptw_result_t ans;
        ans = '0;
        if (op == OP_START)
        begin
            ans.kind = KIND_DONE;
            if (walking)
                ans.status = STATUS_BUSY;
            else if ((va >> VA_BITS) != 0)
                ans.status = STATUS_OUT_RANGE;
            else
            begin
                vpn_held = va[PAGE_OFS_W +: VPN_W];
                walk_lvl = LEVEL_ROOT;
                walking = 1'b1;
                ans.kind = KIND_REQUEST;
                ans.entry_addr = table_slot(root_ppn);
            end
            walker_outputs_due.push_back(ans);
        end
        else if (walking)
        begin
            ans.kind = KIND_DONE;
            if (!pte[PTE_V_BIT])
            begin
                walking = 1'b0;
                walk_lvl = LEVEL_LEAF;
                ans.status = STATUS_NOT_MAPPED;
            end
            else if (walk_lvl != LEVEL_LEAF)
            begin
                // upper levels are always pointers, whatever r/w/x say
                walk_lvl = walk_lvl - 1'b1;
                ans.kind = KIND_REQUEST;
                ans.entry_addr = table_slot(pte[PTE_PPN_LSB +: PPN_W]);
            end
            else
            begin
                walking = 1'b0;
                if (!pte[PTE_U_BIT])
                    ans.status = STATUS_NO_USER;
                else
                    ans.page_addr = PADDR_W'(pte[PTE_PPN_LSB +: PPN_W]) << PAGE_OFS_W;
            end
            walker_outputs_due.push_back(ans);
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (send_gap != 0)
        begin
            send_gap <= send_gap - 1;
            push <= 1'b0;
        end
        else if (words_to_push.size() != 0 && send_idle_pct != 0
                 && $urandom_range(0, 99) < send_idle_pct)
        begin
            send_gap <= $urandom_range(0, 15);
            push <= 1'b0;
        end
        else if (words_to_push.size() != 0)
        begin
            push <= 1'b1;
            operation <= words_to_push[0].op;
            virt_addr <= words_to_push[0].va;
            table_entry <= words_to_push[0].pte;
        end
        else
            push <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            walker_answer(operation, virt_addr, table_entry);
            words_to_push.delete(0);
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n || hold_pop)
            pop <= 1'b0;
        else if (take_gap != 0)
        begin
            take_gap <= take_gap - 1;
            pop <= 1'b0;
        end
        else if (take_idle_pct != 0 && $urandom_range(0, 99) < take_idle_pct)
        begin
            take_gap <= $urandom_range(0, 15);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        ptw_result_t seen;
        ptw_result_t want;
        if (rst_n && pop && !empty)
        begin
            seen.kind = kind;
            seen.entry_addr = entry_addr;
            seen.page_addr = page_addr;
            seen.status = status;
            if (walker_outputs_due.size() == 0)
                flag_mismatch($sformatf({"unexpected result word: kind %0d ",
                                         "entry_addr %h page_addr %h status %0d"},
                                        kind, entry_addr, page_addr, status));
            else
            begin
                want = walker_outputs_due.pop_front();
                if (seen !== want)
                    flag_mismatch($sformatf({"result mismatch (got/want): kind %0d/%0d ",
                                             "entry_addr %h/%h page_addr %h/%h status %0d/%0d"},
                                            seen.kind, want.kind, seen.entry_addr,
                                            want.entry_addr, seen.page_addr, want.page_addr,
                                            seen.status, want.status));
            end
        end
    end

    // long stall on the result side so the block fills and backs up
    initial
    begin
        wait (want_hold);
        hold_pop = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pop = 1'b0;
    end

    function automatic logic [XLEN-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [XLEN-1:0] in_range_va();
        logic [XLEN-1:0] v;
        v = rand64();
        v[XLEN-1:VA_BITS] = '0;
        return v;
    endfunction

    task automatic queue_word(input logic op, input logic [XLEN-1:0] va,
                              input logic [XLEN-1:0] pte);
        walker_word_t w;
        w.op = op;
        w.va = va;
        w.pte = pte;
        words_to_push.push_back(w);
    endtask

    // start plus responses, sometimes broken by a busy start or an invalid entry
    task automatic queue_walk(output int words);
        int lvl;
        logic [XLEN-1:0] pte;
        words = 1;
        queue_word(OP_START, in_range_va(), rand64());
        for (lvl = 2; lvl >= 0; lvl--)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                queue_word(OP_START, rand64(), rand64());
                words++;
            end
            pte = rand64() | 64'h1;
            if (lvl == 0)
                pte[PTE_U_BIT] = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 11) == 0)
                pte[PTE_V_BIT] = 1'b0;
            queue_word(OP_RESPONSE, rand64(), pte);
            words++;
            if (!pte[PTE_V_BIT])
                break;
        end
    endtask

    task automatic random_traffic(input int target);
        int added;
        int pick;
        int n;
        logic [XLEN-1:0] va;
        added = 0;
        while (added < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                queue_walk(n);
                added += n;
            end
            else if (pick < 80)
            begin
                va = rand64();
                va[VA_BITS + $urandom_range(0, XLEN - VA_BITS - 1)] = 1'b1;
                queue_word(OP_START, va, rand64());
                added++;
            end
            else if (pick < 88)
                queue_word(OP_RESPONSE, rand64(), rand64());
            else
            begin
                queue_word(1'($urandom_range(0, 1)), rand64(), rand64());
                added++;
            end
        end
    endtask

    // an invalid entry ends any walk left open, then wait for the block to go quiet
    task automatic settle_phase();
        queue_word(OP_RESPONSE, rand64(), rand64() & ~64'h1);
        while (words_to_push.size() != 0 || walker_outputs_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_root_ppn(input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ROOT_PPN_ADDR;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        root_ppn = value[PPN_W-1:0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[PPN_W-1:0] !== root_ppn)
            flag_mismatch($sformatf("root ppn read back %h, written %h",
                                    prdata[PPN_W-1:0], root_ppn));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed words, root table at reset value
        send_idle_pct = 20;
        take_idle_pct = 20;
        queue_word(OP_START, 64'h0, 64'h0);
        queue_word(OP_RESPONSE, 64'h0, 64'h003F_FFFF_FFFF_FC01);
        queue_word(OP_RESPONSE, 64'h0, 64'h0000_0000_0000_0001);
        queue_word(OP_RESPONSE, 64'h0, 64'h003F_FFFF_FFFF_FC11);
        queue_word(OP_START, 64'h0000_003F_FFFF_FFFF, 64'h0);
        queue_word(OP_START, 64'h0, 64'h0);
        queue_word(OP_RESPONSE, 64'h0, 64'hFFFF_FFFF_FFFF_FFFE);
        queue_word(OP_RESPONSE, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(OP_START, 64'h0000_0040_0000_0000, 64'h0);
        queue_word(OP_START, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        queue_word(OP_START, in_range_va(), 64'h0);
        queue_word(OP_RESPONSE, 64'h0, rand64() | 64'h1);
        queue_word(OP_RESPONSE, 64'h0, rand64() & ~64'h1);
        queue_word(OP_START, in_range_va(), 64'h0);
        queue_word(OP_RESPONSE, 64'h0, rand64() | 64'h1);
        queue_word(OP_RESPONSE, 64'h0, rand64() | 64'h1);
        queue_word(OP_RESPONSE, 64'h0, rand64() & ~64'h1);
        queue_word(OP_START, in_range_va(), 64'h0);
        queue_word(OP_RESPONSE, 64'h0, rand64() | 64'h1);
        queue_word(OP_RESPONSE, 64'h0, rand64() | 64'h1);
        queue_word(OP_RESPONSE, 64'h0, 64'h003F_FFFF_FFFF_FC01);
        // r/w/x set on an upper entry, still followed as a pointer
        queue_word(OP_START, in_range_va(), 64'h0);
        queue_word(OP_RESPONSE, 64'h0, 64'h0000_0000_0000_000F);
        queue_word(OP_RESPONSE, 64'h0, rand64() | 64'h1);
        queue_word(OP_RESPONSE, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        settle_phase();

        write_root_ppn(64'hFFFF_FFFF_FFFF_FFFF);
        random_traffic(425);
        settle_phase();

        // upper bits set, low 44 clear: root ppn of zero
        write_root_ppn(64'hFFFF_F000_0000_0000);
        send_idle_pct = 0;
        take_idle_pct = 20;
        random_traffic(425);
        @(posedge clk);
        want_hold = 1'b1;
        settle_phase();

        write_root_ppn(rand64());
        send_idle_pct = 30;
        take_idle_pct = 0;
        random_traffic(425);
        settle_phase();

        write_root_ppn(rand64());
        send_idle_pct = 0;
        take_idle_pct = 0;
        random_traffic(425);
        settle_phase();

        if (bad_words == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sv39_page_table_walker_top.f
src/ptw_pkg.sv
src/ptw_front.sv
src/ptw_back.sv
src/sv39_page_table_walker_top.sv
dv/tb_sv39_page_table_walker_top.sv
